// ===== hdl/mhpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

	typedef struct packed {
		logic        [1:0]  command;
		logic signed [31:0] item_id;
		logic signed [31:0] item_priority;
	} req_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] popped_id;
		logic signed [31:0] popped_priority;
		logic        [6:0]  entry_total;
		logic               is_empty;
		logic signed [31:0] top_id;
		logic signed [31:0] top_priority;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] id;
		logic signed [31:0] prio;
	} entry_t;

endpackage

// ===== hdl/min_heap_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of (id, priority) pairs held in one on-chip memory.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_stall, req) takes one command word:
// push a pair, pop the minimum, or clear. Each command gives one response
// word on the response channel (rsp_valid, rsp_stall, rsp) with a status,
// the popped pair, the entry count and the current top of the heap.
// Commands are processed one at a time; req_stall is high while a command
// is being worked on. A sift step reads the heap memory, compares the
// moving entry against a parent or the smaller child, and writes one slot.
// A clear, an unused command, a rejected command, a push into an empty
// heap or a pop of the last entry needs no sift step and goes straight
// to the response. A new command is accepted while the previous response
// still waits; the block holds its next response while the previous one
// is stalled by rsp_stall and keeps req_stall high until that response
// moves into the output register.
// Reset empties the heap at once; the memory itself is not cleared.
// ----------------------------------------------------------------------------
module min_heap_priority_queue
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;

	typedef enum logic [2:0] {
		IDLE,
		UP_RD,
		UP_CMP,
		UP_FIN,
		DN_LAST,
		DN_LOAD,
		DN_RD,
		DN_CMP
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  count_q;
	logic [AW-1:0]  pos_q;
	entry_t         cur_q;
	entry_t         top_q;
	logic [1:0]     status_q;
	entry_t         popped_q;
	rsp_t           rsp_q;
	logic           rsp_valid_q;
	logic           done_q;

	entry_t         heap_mem [CAPACITY];
	entry_t         rd_a_q;
	entry_t         rd_b_q;

	logic           accept;
	logic [AW-1:0]  parent_c;
	logic [IW-1:0]  left_c;
	logic [IW-1:0]  right_c;
	logic [IW-1:0]  count_ext;
	logic           l_ok;
	logic           r_ok;
	logic           pick_r;
	entry_t         child_c;
	logic [AW-1:0]  child_idx;
	logic           up_less;
	logic           dn_sink;
	logic [AW-1:0]  ra_c;
	logic [AW-1:0]  rb_c;
	logic           we_c;
	logic [AW-1:0]  wa_c;
	entry_t         wd_c;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != IDLE) || done_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign parent_c  = AW'((pos_q - 1'b1) >> 1);
	assign left_c    = {1'b0, pos_q, 1'b1};
	assign right_c   = left_c + 1'b1;
	assign count_ext = IW'(count_q);
	assign l_ok      = left_c < count_ext;
	assign r_ok      = right_c < count_ext;
	assign pick_r    = r_ok && (rd_b_q.prio < rd_a_q.prio);
	assign child_c   = pick_r ? rd_b_q : rd_a_q;
	assign child_idx = pick_r ? right_c[AW-1:0] : left_c[AW-1:0];
	assign up_less   = cur_q.prio < rd_a_q.prio;
	assign dn_sink   = child_c.prio < cur_q.prio;

	always_comb begin
		ra_c = left_c[AW-1:0];
		if (state_q == DN_LAST) begin
			ra_c = count_q[AW-1:0];
		end else if (state_q == UP_RD) begin
			ra_c = parent_c;
		end
		rb_c = right_c[AW-1:0];
	end

	always_comb begin
		we_c = 1'b0;
		wa_c = pos_q;
		wd_c = cur_q;
		unique case (state_q)
			IDLE: begin
				if (accept && req.command == CMD_PUSH && count_q == '0) begin
					we_c = 1'b1;
					wa_c = '0;
					wd_c = '{id: req.item_id, prio: req.item_priority};
				end
			end
			UP_CMP: begin
				we_c = 1'b1;
				wd_c = up_less ? rd_a_q : cur_q;
			end
			UP_FIN: begin
				we_c = 1'b1;
			end
			DN_RD: begin
				we_c = !l_ok;
			end
			DN_CMP: begin
				we_c = 1'b1;
				wd_c = dn_sink ? child_c : cur_q;
			end
			default: begin
				we_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			heap_mem[wa_c] <= wd_c;
		end
		rd_a_q <= heap_mem[ra_c];
		rd_b_q <= heap_mem[rb_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			cur_q       <= '0;
			top_q       <= '0;
			status_q    <= ST_OK;
			popped_q    <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (we_c && wa_c == '0) begin
				top_q <= wd_c;
			end
			if (done_q && (!rsp_valid_q || !rsp_stall)) begin
				done_q                <= 1'b0;
				rsp_valid_q           <= 1'b1;
				rsp_q.status          <= status_q;
				rsp_q.popped_id       <= popped_q.id;
				rsp_q.popped_priority <= popped_q.prio;
				rsp_q.entry_total     <= 7'(count_q);
				rsp_q.is_empty        <= (count_q == '0);
				rsp_q.top_id          <= (count_q == '0) ? '0 : top_q.id;
				rsp_q.top_priority    <= (count_q == '0) ? '0 : top_q.prio;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						pos_q <= count_q[AW-1:0];
						cur_q <= '{id: req.item_id, prio: req.item_priority};
						unique case (req.command)
							CMD_PUSH: begin
								popped_q <= '0;
								if (count_q == CW'(CAPACITY)) begin
									status_q <= ST_PUSH_FULL;
									done_q   <= 1'b1;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q + 1'b1;
									if (count_q != '0) begin
										state_q <= UP_RD;
									end else begin
										done_q <= 1'b1;
									end
								end
							end
							CMD_POP: begin
								if (count_q == '0) begin
									status_q <= ST_POP_EMPTY;
									popped_q <= '0;
									done_q   <= 1'b1;
								end else begin
									status_q <= ST_OK;
									popped_q <= top_q;
									count_q  <= count_q - 1'b1;
									if (count_q != CW'(1)) begin
										state_q <= DN_LAST;
									end else begin
										done_q <= 1'b1;
									end
								end
							end
							CMD_CLEAR: begin
								status_q <= ST_OK;
								popped_q <= '0;
								count_q  <= '0;
								done_q   <= 1'b1;
							end
							default: begin
								status_q <= ST_OK;
								popped_q <= '0;
								done_q   <= 1'b1;
							end
						endcase
					end
				end
				UP_RD: begin
					state_q <= UP_CMP;
				end
				UP_CMP: begin
					if (up_less) begin
						pos_q   <= parent_c;
						state_q <= (parent_c == '0) ? UP_FIN : UP_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= IDLE;
					end
				end
				UP_FIN: begin
					done_q  <= 1'b1;
					state_q <= IDLE;
				end
				DN_LAST: begin
					state_q <= DN_LOAD;
				end
				DN_LOAD: begin
					cur_q   <= rd_a_q;
					pos_q   <= '0;
					state_q <= DN_RD;
				end
				DN_RD: begin
					if (l_ok) begin
						state_q <= DN_CMP;
					end else begin
						done_q  <= 1'b1;
						state_q <= IDLE;
					end
				end
				DN_CMP: begin
					if (dn_sink) begin
						pos_q   <= child_idx;
						state_q <= DN_RD;
					end else begin
						done_q  <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_sink_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == DN_CMP |-> IW'(pos_q) < count_ext)
		else $error("sift-down position outside the heap");

	a_empty_pop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_POP_EMPTY |->
		rsp.popped_id == '0 && rsp.popped_priority == '0 && rsp.is_empty)
		else $error("failed pop reports a popped entry");

	a_empty_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> rsp.top_id == '0 && rsp.top_priority == '0)
		else $error("empty heap reports a top entry");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != IDLE || done_q)
		else $error("accepted word left no work in flight");
`endif

endmodule
